@@ rtl/core/cfb_pkg.sv @@
`timescale 1ns / 1ps

package cfb_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int FIFO_DEPTH_DEF  = 8;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [7:0]  PAD_BYTE = 8'hff;

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // sequencer phases
    localparam logic [2:0] PH_HDR_FIRST  = 3'd1;
    localparam logic [2:0] PH_HDR_LEN_LO = 3'd2;
    localparam logic [2:0] PH_HDR_LAST   = 3'd3;
    localparam logic [2:0] PH_CRC_LO     = 3'd4;
    localparam logic [2:0] PH_CRC_HI     = 3'd5;

    typedef struct packed {
        logic        action;
        logic [15:0] command;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
    } cfb_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } cfb_out_t;

    // one queued job for the serializer
    typedef struct packed {
        logic        is_start;
        logic        bad_len;
        logic        final_byte;
        logic [15:0] command;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
    } cfb_job_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_HDR   = 3'b010,
        ST_TRAIL = 3'b100
    } cfb_state_t;

    // CRC-16 poly 0x8005, MSB first, one byte
    function automatic logic [15:0] cfb_crc_feed(input logic [15:0] crc, input logic [7:0] din);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ din[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/crc16_frame_builder_unit.sv @@
// Path: an input item is written into the job queue, and its first byte is then
// registered into the output register once the serializer is idle and can load.
// Throughput: one input item per cycle while the job queue has room; the
// serializer sends one byte per cycle unless stalled by m_ready: 1 per payload
// byte, 4 per start, 7 for the final one, so output bytes set the sustained rate.
// Reset: synchronous active-low aresetn; clears queue, frame state and CRC.
`timescale 1ns / 1ps

module crc16_frame_builder_unit import cfb_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cfb_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output cfb_out_t m_payload
);

    logic     q_push, q_full, q_pop, q_empty;
    cfb_job_t q_job, head_job;

    cfb_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .q_push   (q_push),
        .q_job    (q_job),
        .q_full   (q_full)
    );

    cfb_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_job(q_job),
        .full    (q_full),
        .pop     (q_pop),
        .head_job(head_job),
        .empty   (q_empty)
    );

    cfb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

endmodule

@@ rtl/core/cfb_front.sv @@
`timescale 1ns / 1ps

module cfb_front import cfb_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cfb_in_t  s_payload,
    output logic     q_push,
    output cfb_job_t q_job,
    input  logic     q_full
);

    logic        active_reg, active_next;
    logic [15:0] remain_reg, remain_next;
    logic        accept;
    logic        bad_len;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign bad_len = (s_payload.frame_length == 16'd0) ||
                     ({1'b0, s_payload.frame_length} > 17'(MAX_PAYLOAD));

    always_comb begin
        active_next        = active_reg;
        remain_next        = remain_reg;
        q_push             = 1'b0;
        q_job.is_start     = (s_payload.action == ACT_START);
        q_job.bad_len      = bad_len;
        q_job.final_byte   = (remain_reg == 16'd1);
        q_job.command      = s_payload.command;
        q_job.frame_length = s_payload.frame_length;
        q_job.data_byte    = s_payload.data_byte;
        if (accept) begin
            if (s_payload.action == ACT_START) begin
                q_push      = 1'b1;
                active_next = !bad_len;
                remain_next = s_payload.frame_length;
            end else if (active_reg) begin
                q_push      = 1'b1;
                remain_next = remain_reg - 16'd1;
                if (remain_reg == 16'd1) begin
                    active_next = 1'b0;
                end
            end
            // payload while idle is dropped
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            remain_reg <= '0;
        end else begin
            active_reg <= active_next;
            remain_reg <= remain_next;
        end
    end

endmodule

@@ rtl/core/cfb_fifo.sv @@
`timescale 1ns / 1ps

module cfb_fifo import cfb_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  cfb_job_t push_job,
    output logic     full,
    input  logic     pop,
    output cfb_job_t head_job,
    output logic     empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfb_job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/cfb_back.sv @@
`timescale 1ns / 1ps

module cfb_back import cfb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfb_job_t head_job,
    input  logic     q_empty,
    output logic     q_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output cfb_out_t m_payload
);

    cfb_state_t  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    cfb_job_t    hdr_reg, hdr_next;
    logic        out_valid_reg, out_valid_next;
    cfb_out_t    out_reg, out_next;
    logic        load;
    logic [7:0]  hdr_byte;

    assign load      = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    always_comb begin
        case (phase_reg)
            PH_HDR_FIRST:  hdr_byte = hdr_reg.command[15:8];
            PH_HDR_LEN_LO: hdr_byte = hdr_reg.frame_length[7:0];
            default:       hdr_byte = hdr_reg.frame_length[15:8];
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        crc_next       = crc_reg;
        hdr_next       = hdr_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        if (load) begin
            out_valid_next = 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_next.last  = 1'b0;
                        out_next.error = 1'b0;
                        if (head_job.is_start) begin
                            // new frame restarts the CRC, abandoning any open frame
                            out_next.out_byte = head_job.command[7:0];
                            crc_next          = cfb_crc_feed(16'd0, head_job.command[7:0]);
                            hdr_next          = head_job;
                            phase_next        = PH_HDR_FIRST;
                            state_next        = ST_HDR;
                        end else begin
                            out_next.out_byte = head_job.data_byte;
                            crc_next          = cfb_crc_feed(crc_reg, head_job.data_byte);
                            if (head_job.final_byte) begin
                                phase_next = '0;
                                state_next = ST_TRAIL;
                            end
                        end
                    end
                end
                ST_HDR: begin
                    out_valid_next    = 1'b1;
                    out_next.out_byte = hdr_byte;
                    out_next.last     = 1'b0;
                    out_next.error    = 1'b0;
                    crc_next          = cfb_crc_feed(crc_reg, hdr_byte);
                    phase_next        = phase_reg + 3'd1;
                    if (phase_reg == PH_HDR_LAST) begin
                        out_next.last  = hdr_reg.bad_len;
                        out_next.error = hdr_reg.bad_len;
                        state_next     = ST_IDLE;
                    end
                end
                ST_TRAIL: begin
                    out_valid_next = 1'b1;
                    out_next.last  = 1'b0;
                    out_next.error = 1'b0;
                    phase_next     = phase_reg + 3'd1;
                    case (phase_reg)
                        PH_CRC_LO: out_next.out_byte = crc_reg[7:0];
                        PH_CRC_HI: begin
                            out_next.out_byte = crc_reg[15:8];
                            out_next.last     = 1'b1;
                            crc_next          = '0;
                            state_next        = ST_IDLE;
                        end
                        default:   out_next.out_byte = PAD_BYTE;
                    endcase
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg <= hdr_next;
        out_reg <= out_next;
    end

endmodule

@@ rtl/core/cfb_checker.sv @@
`timescale 1ns / 1ps

module cfb_checker import cfb_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input cfb_in_t  s_payload,
    input logic     m_valid,
    input logic     m_ready,
    input cfb_out_t m_payload
);

    // a stalled transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("output changed while stalled");

    // a waiting input transfer holds its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("input changed while waiting");

    // error flag only on the closing byte
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.error |-> m_payload.last)
        else $error("error without last");

    // output only starts up after an input transfer, via the job queue and output register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("output without a prior transfer");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind crc16_frame_builder_unit cfb_checker u_cfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_payload(s_payload),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_payload(m_payload)
);
